// File: hdl/npsp_pkg.sv
// Shared types, codes and constants of the nearest point and segment picker.
// Used by every module under hdl; depends on nothing else.
package npsp_pkg;

  localparam int CW  = 32;  // arithmetic coordinate width
  localparam int LIW = 10;  // line end index width
  localparam int OIW = 10;  // result index width
  localparam int PW  = 64;  // product width
  localparam int AW  = 66;  // signed accumulator width
  localparam int LW  = 65;  // squared length width
  localparam int SQW = 130; // squared cross product width

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_LINES    = 1024;
  localparam int DEF_COORD_BITS   = 32;

  typedef enum logic [2:0] {
    MODE_ADD_VERTEX  = 3'd0,
    MODE_ADD_LINE    = 3'd1,
    MODE_CLEAR       = 3'd2,
    MODE_PICK_VERTEX = 3'd3,
    MODE_PICK_LINE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [LIW-1:0] start_idx;
    logic [LIW-1:0] end_idx;
    logic           complete;
  } line_ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RAD, S_RADW,
    S_V_RD, S_V_DAT,
    S_L_RD, S_L_DAT, S_L_A, S_L_B,
    S_L_E1, S_L_E2, S_L_E3, S_L_D1, S_L_D2, S_L_C1, S_L_C2, S_L_DIV,
    S_D_M1, S_D_M2, S_D_M3, S_CMP
  } seq_state_t;

  typedef enum logic [1:0] {
    SD_IDLE, SD_SQUARE, SD_CHECK, SD_DIVIDE
  } sd_state_t;

  // magnitude of a signed coordinate difference
  function automatic logic [CW-1:0] mag33(input logic signed [CW:0] v);
    logic [CW:0] t;
    t = v[CW] ? (~v + 1'b1) : v;
    return t[CW-1:0];
  endfunction

endpackage

// File: hdl/npsp_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on npsp_pkg.
module npsp_mul (
  input  logic                   clk,
  input  logic [npsp_pkg::CW-1:0] a,
  input  logic [npsp_pkg::CW-1:0] b,
  output logic [npsp_pkg::PW-1:0] p
);
  import npsp_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: hdl/npsp_store.sv
// Vertex and line tables: single write port, registered read port each.
// Depends on npsp_pkg.
module npsp_store #(
  parameter int MAX_VERTICES = npsp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_LINES    = npsp_pkg::DEF_MAX_LINES,
  parameter int COORD_BITS   = npsp_pkg::DEF_COORD_BITS,
  localparam int VAW = $clog2(MAX_VERTICES),
  localparam int LAW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
  input  logic                           clk,
  input  logic                           vtx_we,
  input  logic [VAW-1:0]                 vtx_waddr,
  input  logic signed [npsp_pkg::CW-1:0] vtx_wx,
  input  logic signed [npsp_pkg::CW-1:0] vtx_wy,
  input  logic [VAW-1:0]                 vtx_raddr,
  output logic signed [npsp_pkg::CW-1:0] vtx_rx,
  output logic signed [npsp_pkg::CW-1:0] vtx_ry,
  input  logic                           line_we,
  input  logic [LAW-1:0]                 line_waddr,
  input  npsp_pkg::line_ent_t            line_wdata,
  input  logic [LAW-1:0]                 line_raddr,
  output npsp_pkg::line_ent_t            line_rdata
);
  import npsp_pkg::*;

  logic [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
  logic [COORD_BITS-1:0] vy_mem [MAX_VERTICES];
  line_ent_t             ln_mem [MAX_LINES];
  logic [COORD_BITS-1:0] vx_q;
  logic [COORD_BITS-1:0] vy_q;

  always_ff @(posedge clk) begin
    if (vtx_we) begin
      vx_mem[vtx_waddr] <= vtx_wx[COORD_BITS-1:0];
      vy_mem[vtx_waddr] <= vtx_wy[COORD_BITS-1:0];
    end
    vx_q <= vx_mem[vtx_raddr];
    vy_q <= vy_mem[vtx_raddr];
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      ln_mem[line_waddr] <= line_wdata;
    end
    line_rdata <= ln_mem[line_raddr];
  end

  // sign-extend stored coordinates to the arithmetic width
  assign vtx_rx = CW'($signed(vx_q));
  assign vtx_ry = CW'($signed(vy_q));

endmodule

// File: hdl/npsp_sqdiv.sv
// Bit-serial square of the cross product, then restoring division by the
// squared segment length, saturated at 2^64-1. Depends on npsp_pkg.
module npsp_sqdiv (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [npsp_pkg::LW-1:0] mag,
  input  logic [npsp_pkg::LW-1:0] den,
  output logic                    done,
  output logic [npsp_pkg::PW-1:0] quot
);
  import npsp_pkg::*;

  sd_state_t       state, state_next;
  logic [LW-1:0]   m, m_next;
  logic [LW-1:0]   d, d_next;
  logic [SQW-1:0]  acc, acc_next;
  logic [AW-1:0]   rem, rem_next;
  logic [6:0]      cnt, cnt_next;
  logic [PW-1:0]   q_next;
  logic            done_next;
  logic [AW:0]     trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    m    <= m_next;
    d    <= d_next;
    acc  <= acc_next;
    rem  <= rem_next;
    cnt  <= cnt_next;
    quot <= q_next;
  end

  always_comb begin
    state_next = state;
    m_next     = m;
    d_next     = d;
    acc_next   = acc;
    rem_next   = rem;
    cnt_next   = cnt;
    q_next     = quot;
    done_next  = 1'b0;
    trial      = {rem, acc[cnt[5:0]]};
    case (state)
      SD_IDLE: begin
        if (start) begin
          m_next     = mag;
          d_next     = den;
          acc_next   = '0;
          cnt_next   = 7'(LW - 1);
          state_next = SD_SQUARE;
        end
      end
      SD_SQUARE: begin
        // shift-add, most significant multiplier bit first
        acc_next = (acc << 1) + (m[cnt] ? SQW'(m) : '0);
        if (cnt == '0) begin
          state_next = SD_CHECK;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      SD_CHECK: begin
        if (acc >= {1'b0, d, {PW{1'b0}}}) begin
          q_next     = '1;
          done_next  = 1'b1;
          state_next = SD_IDLE;
        end else begin
          rem_next   = acc[SQW-1:PW];
          q_next     = '0;
          cnt_next   = 7'(PW - 1);
          state_next = SD_DIVIDE;
        end
      end
      SD_DIVIDE: begin
        if (trial >= (AW+1)'(d)) begin
          rem_next = AW'(trial - (AW+1)'(d));
          q_next   = {quot[PW-2:0], 1'b1};
        end else begin
          rem_next = trial[AW-1:0];
          q_next   = {quot[PW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          done_next  = 1'b1;
          state_next = SD_IDLE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      default: state_next = SD_IDLE;
    endcase
  end

endmodule

// File: hdl/nearest_point_and_segment_pick.sv
// Top level of the nearest point and segment picker: sequencer and datapath.
// Depends on npsp_pkg, npsp_store, npsp_mul and npsp_sqdiv.
//
//   channel   | direction | payload (lowest bit first)
//   ----------+-----------+-------------------------------------------------
//   s_tdata   | in        | mode, point_x, point_y, pick_radius,
//             |           | start_index, end_index, ends_present (120 bits)
//   m_tdata   | out       | status, entry_index (16 bits)
//
// Add, clear and unused modes offer their result in the cycle after the transfer.
// A vertex pick squares the radius, then reads, squares and compares each
// vertex in turn; the shared multiplier sets the per-vertex cost. A line pick
// skips a line with a missing or absent end after reading it, takes the plain
// squared distance for a usable line with a clamped or zero-length projection,
// and for a line whose projection falls inside runs the bit-serial square, the
// saturation check and the restoring divider, which is skipped on saturation.
// Reset clears the counts and the control state; tables need no clearing.
// One item is in flight at a time; a waiting result holds off new transfers.
module nearest_point_and_segment_pick #(
  parameter int MAX_VERTICES = npsp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_LINES    = npsp_pkg::DEF_MAX_LINES,
  parameter int COORD_BITS   = npsp_pkg::DEF_COORD_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode[2:0] point_x[34:3] point_y[66:35] pick_radius[97:67]
  // start_index[107:98] end_index[117:108] ends_present[118] zero[119]
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0] entry_index[11:2] zero[15:12]
  output logic [15:0]  m_tdata
);
  import npsp_pkg::*;

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int LAW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int LCW = $clog2(MAX_LINES + 1);
  localparam int IW  = (VCW > LCW) ? VCW : LCW;

  // unpack the input transfer
  logic [2:0]      in_mode;
  logic [CW-1:0]   in_x_raw;
  logic [CW-1:0]   in_y_raw;
  logic [30:0]     in_rad;
  line_ent_t       in_line;

  assign in_mode            = s_tdata[2:0];
  assign in_x_raw           = s_tdata[34:3];
  assign in_y_raw           = s_tdata[66:35];
  assign in_rad             = s_tdata[97:67];
  assign in_line.start_idx  = s_tdata[107:98];
  assign in_line.end_idx    = s_tdata[117:108];
  assign in_line.complete   = s_tdata[118];

  // state and datapath registers
  seq_state_t          state, state_next;
  logic [VCW-1:0]      vcount, vcount_next;
  logic [LCW-1:0]      lcount, lcount_next;
  logic [IW-1:0]       i, i_next;
  logic [IW-1:0]       idx, idx_next;
  logic                found, found_next;
  logic [PW-1:0]       best, best_next;
  logic [PW-1:0]       cand, cand_next;
  logic [2:0]          mode, mode_next;
  logic signed [CW-1:0] px, px_next, py, py_next;
  logic signed [CW-1:0] ax, ax_next, ay, ay_next;
  logic [30:0]         rad, rad_next;
  logic [CW-1:0]       mx, mx_next, my, my_next;
  logic [PW-1:0]       s1, s1_next;
  logic signed [AW-1:0] acc, acc_next;
  logic [LW-1:0]       len2, len2_next;
  logic signed [CW:0]  ex, ex_next, ey, ey_next;
  logic signed [CW:0]  wx, wx_next, wy, wy_next;
  logic signed [CW:0]  bdx, bdx_next, bdy, bdy_next;
  logic [LIW-1:0]      le, le_next;
  logic                mul_neg, mul_neg_next;
  logic                out_valid, out_valid_next;
  logic [1:0]          out_status, out_status_next;
  logic [OIW-1:0]      out_index, out_index_next;

  // unit connections
  logic                 vtx_we, line_we;
  logic [VAW-1:0]       vtx_raddr;
  logic [LAW-1:0]       line_raddr;
  logic signed [CW-1:0] vtx_rx, vtx_ry;
  line_ent_t            line_rdata;
  logic [CW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        mul_p;
  logic signed [AW-1:0] sp;
  logic signed [AW-1:0] sum;
  logic [PW:0]          d2;
  logic                 sd_start, sd_done;
  logic [LW-1:0]        sd_mag;
  logic [PW-1:0]        sd_quot;
  logic signed [CW-1:0] in_x, in_y;
  logic [31:0]          vcount_ext, lcount_ext, i_ext, idx_ext;
  logic [31:0]          le_ext, rd_s_ext, rd_e_ext;

  // coordinates are the low COORD_BITS bits, sign-extended
  assign in_x = CW'($signed(in_x_raw[COORD_BITS-1:0]));
  assign in_y = CW'($signed(in_y_raw[COORD_BITS-1:0]));

  assign vcount_ext = 32'(vcount);
  assign lcount_ext = 32'(lcount);
  assign i_ext      = 32'(i);
  assign idx_ext    = 32'(idx);
  assign rd_s_ext   = 32'(line_rdata.start_idx);
  assign rd_e_ext   = 32'(line_rdata.end_idx);
  assign le_ext     = 32'(le);

  // signed view of the last product, and running sum with it
  assign sp  = mul_neg ? (AW'(0) - AW'(mul_p)) : AW'(mul_p);
  assign sum = acc + sp;
  assign d2  = (PW+1)'(s1) + (PW+1)'(mul_p);
  assign sd_mag = sum[AW-1] ? LW'(AW'(0) - sum) : LW'(sum);

  assign s_tready = (state == S_IDLE) && !out_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_index, out_status};

  npsp_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_LINES    (MAX_LINES),
    .COORD_BITS   (COORD_BITS)
  ) u_store (
    .clk        (clk),
    .vtx_we     (vtx_we),
    .vtx_waddr  (vcount[VAW-1:0]),
    .vtx_wx     (in_x),
    .vtx_wy     (in_y),
    .vtx_raddr  (vtx_raddr),
    .vtx_rx     (vtx_rx),
    .vtx_ry     (vtx_ry),
    .line_we    (line_we),
    .line_waddr (lcount[LAW-1:0]),
    .line_wdata (in_line),
    .line_raddr (line_raddr),
    .line_rdata (line_rdata)
  );

  npsp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  npsp_sqdiv u_sqdiv (
    .clk   (clk),
    .rst   (rst),
    .start (sd_start),
    .mag   (sd_mag),
    .den   (len2),
    .done  (sd_done),
    .quot  (sd_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= '0;
      lcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      vcount    <= vcount_next;
      lcount    <= lcount_next;
      out_valid <= out_valid_next;
    end
    i          <= i_next;
    idx        <= idx_next;
    found      <= found_next;
    best       <= best_next;
    cand       <= cand_next;
    mode       <= mode_next;
    px         <= px_next;
    py         <= py_next;
    ax         <= ax_next;
    ay         <= ay_next;
    rad        <= rad_next;
    mx         <= mx_next;
    my         <= my_next;
    s1         <= s1_next;
    acc        <= acc_next;
    len2       <= len2_next;
    ex         <= ex_next;
    ey         <= ey_next;
    wx         <= wx_next;
    wy         <= wy_next;
    bdx        <= bdx_next;
    bdy        <= bdy_next;
    le         <= le_next;
    mul_neg    <= mul_neg_next;
    out_status <= out_status_next;
    out_index  <= out_index_next;
  end

  always_comb begin
    state_next      = state;
    vcount_next     = vcount;
    lcount_next     = lcount;
    i_next          = i;
    idx_next        = idx;
    found_next      = found;
    best_next       = best;
    cand_next       = cand;
    mode_next       = mode;
    px_next         = px;
    py_next         = py;
    ax_next         = ax;
    ay_next         = ay;
    rad_next        = rad;
    mx_next         = mx;
    my_next         = my;
    s1_next         = s1;
    acc_next        = acc;
    len2_next       = len2;
    ex_next         = ex;
    ey_next         = ey;
    wx_next         = wx;
    wy_next         = wy;
    bdx_next        = bdx;
    bdy_next        = bdy;
    le_next         = le;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_index_next  = out_index;
    vtx_we          = 1'b0;
    line_we         = 1'b0;
    vtx_raddr       = i[VAW-1:0];
    line_raddr      = i[LAW-1:0];
    mul_a           = mx;
    mul_b           = mx;
    mul_neg_next    = 1'b0;
    sd_start        = 1'b0;

    // drop the result once the sink takes the transfer
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          mode_next       = in_mode;
          px_next         = in_x;
          py_next         = in_y;
          rad_next        = in_rad;
          i_next          = '0;
          idx_next        = '0;
          found_next      = 1'b0;
          out_status_next = STAT_OK;
          out_index_next  = '0;
          case (mode_t'(in_mode))
            MODE_ADD_VERTEX: begin
              out_valid_next = 1'b1;
              if (vcount_ext >= 32'(MAX_VERTICES)) begin
                out_status_next = STAT_FULL;
              end else begin
                vtx_we         = 1'b1;
                out_index_next = vcount_ext[OIW-1:0];
                vcount_next    = vcount + 1'b1;
              end
            end
            MODE_ADD_LINE: begin
              out_valid_next = 1'b1;
              if (lcount_ext >= 32'(MAX_LINES)) begin
                out_status_next = STAT_FULL;
              end else begin
                line_we        = 1'b1;
                out_index_next = lcount_ext[OIW-1:0];
                lcount_next    = lcount + 1'b1;
              end
            end
            MODE_CLEAR: begin
              out_valid_next = 1'b1;
              vcount_next    = '0;
              lcount_next    = '0;
            end
            MODE_PICK_VERTEX, MODE_PICK_LINE: begin
              state_next = S_RAD;
            end
            default: out_valid_next = 1'b1;
          endcase
        end
      end
      // squared radius is the starting bound
      S_RAD: begin
        mul_a      = CW'(rad);
        mul_b      = CW'(rad);
        state_next = S_RADW;
      end
      S_RADW: begin
        best_next  = mul_p;
        state_next = (mode_t'(mode) == MODE_PICK_VERTEX) ? S_V_RD : S_L_RD;
      end
      S_V_RD: begin
        if (i_ext >= vcount_ext) begin
          out_valid_next  = 1'b1;
          out_status_next = found ? STAT_OK : STAT_NONE;
          out_index_next  = found ? idx_ext[OIW-1:0] : '0;
          state_next      = S_IDLE;
        end else begin
          state_next = S_V_DAT;
        end
      end
      S_V_DAT: begin
        mx_next    = mag33({vtx_rx[CW-1], vtx_rx} - {px[CW-1], px});
        my_next    = mag33({vtx_ry[CW-1], vtx_ry} - {py[CW-1], py});
        state_next = S_D_M1;
      end
      S_L_RD: begin
        if (i_ext >= lcount_ext) begin
          out_valid_next  = 1'b1;
          out_status_next = found ? STAT_OK : STAT_NONE;
          out_index_next  = found ? idx_ext[OIW-1:0] : '0;
          state_next      = S_IDLE;
        end else begin
          state_next = S_L_DAT;
        end
      end
      // skip lines with a missing end or an end index at or past the vertex count
      S_L_DAT: begin
        vtx_raddr = rd_s_ext[VAW-1:0];
        le_next   = line_rdata.end_idx;
        if (!line_rdata.complete || rd_s_ext >= vcount_ext ||
            rd_e_ext >= vcount_ext) begin
          i_next     = i + 1'b1;
          state_next = S_L_RD;
        end else begin
          state_next = S_L_A;
        end
      end
      S_L_A: begin
        ax_next    = vtx_rx;
        ay_next    = vtx_ry;
        vtx_raddr  = le_ext[VAW-1:0];
        state_next = S_L_B;
      end
      S_L_B: begin
        ex_next    = {vtx_rx[CW-1], vtx_rx} - {ax[CW-1], ax};
        ey_next    = {vtx_ry[CW-1], vtx_ry} - {ay[CW-1], ay};
        wx_next    = {px[CW-1], px} - {ax[CW-1], ax};
        wy_next    = {py[CW-1], py} - {ay[CW-1], ay};
        bdx_next   = {px[CW-1], px} - {vtx_rx[CW-1], vtx_rx};
        bdy_next   = {py[CW-1], py} - {vtx_ry[CW-1], vtx_ry};
        state_next = S_L_E1;
      end
      // squared length
      S_L_E1: begin
        mul_a      = mag33(ex);
        mul_b      = mag33(ex);
        state_next = S_L_E2;
      end
      S_L_E2: begin
        acc_next   = sp;
        mul_a      = mag33(ey);
        mul_b      = mag33(ey);
        state_next = S_L_E3;
      end
      S_L_E3: begin
        len2_next    = LW'(sum);
        mul_a        = mag33(wx);
        mul_b        = mag33(ex);
        mul_neg_next = wx[CW] ^ ex[CW];
        state_next   = S_L_D1;
      end
      // projection, then pick the clamped case
      S_L_D1: begin
        acc_next     = sp;
        mul_a        = mag33(wy);
        mul_b        = mag33(ey);
        mul_neg_next = wy[CW] ^ ey[CW];
        state_next   = S_L_D2;
      end
      S_L_D2: begin
        mul_a        = mag33(wx);
        mul_b        = mag33(ey);
        mul_neg_next = wx[CW] ^ ey[CW];
        if (len2 == '0 || sum[AW-1] || sum == '0) begin
          mx_next    = mag33(wx);
          my_next    = mag33(wy);
          state_next = S_D_M1;
        end else if (LW'(sum) >= len2) begin
          mx_next    = mag33(bdx);
          my_next    = mag33(bdy);
          state_next = S_D_M1;
        end else begin
          state_next = S_L_C1;
        end
      end
      // cross product, then square and divide
      S_L_C1: begin
        acc_next     = sp;
        mul_a        = mag33(wy);
        mul_b        = mag33(ex);
        mul_neg_next = ~(wy[CW] ^ ex[CW]);
        state_next   = S_L_C2;
      end
      S_L_C2: begin
        sd_start   = 1'b1;
        state_next = S_L_DIV;
      end
      S_L_DIV: begin
        if (sd_done) begin
          cand_next  = sd_quot;
          state_next = S_CMP;
        end
      end
      // plain squared distance, saturated
      S_D_M1: begin
        mul_a      = mx;
        mul_b      = mx;
        state_next = S_D_M2;
      end
      S_D_M2: begin
        s1_next    = mul_p;
        mul_a      = my;
        mul_b      = my;
        state_next = S_D_M3;
      end
      S_D_M3: begin
        cand_next  = d2[PW] ? '1 : d2[PW-1:0];
        state_next = S_CMP;
      end
      // equal distance: the later entry wins
      S_CMP: begin
        if (cand <= best) begin
          best_next  = cand;
          idx_next   = i;
          found_next = 1'b1;
        end
        i_next     = i + 1'b1;
        state_next = (mode_t'(mode) == MODE_PICK_VERTEX) ? S_V_RD : S_L_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: bench/nearest_point_and_segment_pick_test.sv
// Self-checking bench for nearest_point_and_segment_pick: vertex and line tables,
// nearest picks in squared distance. Depends on npsp_pkg and the block itself.
`timescale 1ns / 100ps

module nearest_point_and_segment_pick_test;
  import npsp_pkg::*;

  localparam int      NV        = 1024;
  localparam int      NL        = 1024;
  localparam longint  CYC_LIMIT = 4_000_000;
  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;
  localparam logic [63:0] SQ_SAT = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    status_t        status;
    logic [OIW-1:0] index;
  } pick_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // mode, point_x, point_y, pick_radius, start_index, end_index, ends_present, zero
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // status, entry_index, zero
  logic [15:0]  m_tdata;

  nearest_point_and_segment_pick u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block's tables
  logic signed [31:0] vx_shadow [NV];
  logic signed [31:0] vy_shadow [NV];
  logic [9:0]         ls_shadow [NL];
  logic [9:0]         le_shadow [NL];
  logic               lc_shadow [NL];
  int                 vtx_count, line_count;

  pick_result_t pending_results [$];
  int  fail_count, sent_count, seen_count;
  int  send_idle_pct, recv_stall_pct;
  int  hold_cycles;
  longint cycle_count;

  // Squared distance, saturated to 64 bits
  function automatic logic [63:0] sq_len(input logic signed [159:0] dx,
                                         input logic signed [159:0] dy);
    logic signed [159:0] s;
    s = dx * dx + dy * dy;
    return (s > $signed({96'd0, SQ_SAT})) ? SQ_SAT : s[63:0];
  endfunction

  // Squared distance from p to segment a-b, clamped projection
  function automatic logic [63:0] seg_sq(
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] ax, input logic signed [31:0] ay,
      input logic signed [31:0] bx, input logic signed [31:0] by);
    logic signed [159:0] wx, wy, ex, ey, len2, dot, cr, sq, q;
    wx = px - ax;  wy = py - ay;
    ex = bx - ax;  ey = by - ay;
    len2 = ex * ex + ey * ey;
    dot  = wx * ex + wy * ey;
    if (len2 == 0 || dot <= 0) return sq_len(wx, wy);
    if (dot >= len2) begin
      wx = px - bx;  wy = py - by;
      return sq_len(wx, wy);
    end
    cr = wx * ey - wy * ex;
    sq = cr * cr;
    q  = sq / len2;
    return (q > $signed({96'd0, SQ_SAT})) ? SQ_SAT : q[63:0];
  endfunction

  // Work out the result of one accepted item and advance the shadow tables
  function automatic pick_result_t predict_pick(
      input logic [2:0] mode, input logic signed [31:0] px,
      input logic signed [31:0] py, input logic [30:0] rad,
      input logic [9:0] si, input logic [9:0] ei, input logic ep);
    pick_result_t r;
    logic [63:0] best, d;
    logic found;
    r.status = STAT_OK;
    r.index  = '0;
    best  = 64'(rad) * 64'(rad);
    found = 1'b0;
    case (mode)
      MODE_ADD_VERTEX: begin
        if (vtx_count >= NV) r.status = STAT_FULL;
        else begin
          vx_shadow[vtx_count] = px;
          vy_shadow[vtx_count] = py;
          r.index = vtx_count[9:0];
          vtx_count++;
        end
      end
      MODE_ADD_LINE: begin
        if (line_count >= NL) r.status = STAT_FULL;
        else begin
          ls_shadow[line_count] = si;
          le_shadow[line_count] = ei;
          lc_shadow[line_count] = ep;
          r.index = line_count[9:0];
          line_count++;
        end
      end
      MODE_CLEAR: begin
        vtx_count  = 0;
        line_count = 0;
      end
      MODE_PICK_VERTEX: begin
        for (int i = 0; i < vtx_count; i++) begin
          d = sq_len(160'(vx_shadow[i]) - 160'(px), 160'(vy_shadow[i]) - 160'(py));
          if (d <= best) begin
            best = d; r.index = i[9:0]; found = 1'b1;
          end
        end
        if (!found) r.status = STAT_NONE;
      end
      MODE_PICK_LINE: begin
        for (int i = 0; i < line_count; i++) begin
          if (lc_shadow[i] && ls_shadow[i] < vtx_count && le_shadow[i] < vtx_count) begin
            d = seg_sq(px, py, vx_shadow[ls_shadow[i]], vy_shadow[ls_shadow[i]],
                       vx_shadow[le_shadow[i]], vy_shadow[le_shadow[i]]);
            if (d <= best) begin
              best = d; r.index = i[9:0]; found = 1'b1;
            end
          end
        end
        if (!found) r.status = STAT_NONE;
      end
      default: ;
    endcase
    if (!found && (mode == MODE_PICK_VERTEX || mode == MODE_PICK_LINE)) r.index = '0;
    return r;
  endfunction

  // Offer one item; returns just after the edge where the transfer happened
  task automatic send_item(input logic [2:0] mode, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic [30:0] rad,
                           input logic [9:0] si, input logic [9:0] ei, input logic ep);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, ep, ei, si, rad, py, px, mode};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    pending_results.insert(pending_results.size(),
                           predict_pick(mode, px, py, rad, si, ei, ep));
    sent_count++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample results on the falling edge ahead of the transfer edge
  always @(negedge clk) begin
    pick_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      seen_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[1:0] !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[11:2] !== exp_r.index) begin
          $display("%0t: entry_index expected %0d actual %0d", $time, exp_r.index,
                   m_tdata[11:2]);
          fail_count++;
        end
        if (m_tdata[15:12] !== 4'd0) begin
          $display("%0t: padding expected 0 actual %h", $time, m_tdata[15:12]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord;
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic logic [30:0] rand_radius;
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(32'h0010_0000));
    endcase
  endfunction

  // Extremes, every mode and each corner case by hand
  task automatic test_directed;
    send_item(MODE_PICK_VERTEX, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);   // empty table
    send_item(MODE_PICK_LINE, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);
    send_item(MODE_ADD_VERTEX, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0);
    send_item(MODE_ADD_VERTEX, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
    send_item(MODE_ADD_VERTEX, 0, 0, 0, 0, 0, 0);
    send_item(MODE_ADD_VERTEX, 0, 0, 0, 0, 0, 0);                // duplicate point
    send_item(MODE_ADD_VERTEX, 32'sh0001_0000, 0, 0, 0, 0, 0);
    send_item(MODE_PICK_VERTEX, 0, 0, 0, 0, 0, 0);               // tie: later wins
    send_item(MODE_PICK_VERTEX, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0);
    send_item(MODE_PICK_VERTEX, 32'sh0000_8000, 32'sh0100_0000, 31'h0000_0010, 0, 0, 0);
    send_item(MODE_ADD_LINE, 0, 0, 0, 10'd2, 10'd4, 1'b1);       // normal segment
    send_item(MODE_ADD_LINE, 0, 0, 0, 10'd3, 10'd3, 1'b1);       // zero length
    send_item(MODE_ADD_LINE, 0, 0, 0, 10'd2, 10'd4, 1'b0);       // missing end
    send_item(MODE_ADD_LINE, 0, 0, 0, 10'd5, 10'h3FF, 1'b1);     // end not present
    send_item(MODE_ADD_LINE, 0, 0, 0, 10'd0, 10'd1, 1'b1);       // extreme span
    send_item(MODE_PICK_LINE, 32'sh0000_8000, 32'sh0000_4000, 31'h7FFF_FFFF, 0, 0, 0);
    send_item(MODE_PICK_LINE, -32'sh0001_0000, 32'sh0000_1000, 31'h0002_0000, 0, 0, 0);
    send_item(MODE_PICK_LINE, 32'sh0003_0000, 0, 31'h0003_0000, 0, 0, 0);
    send_item(MODE_PICK_LINE, 32'sh4000_0000, -32'sh4000_0000, 31'h7FFF_FFFF, 0, 0, 0);
    send_item(MODE_PICK_LINE, 32'sh0100_0000, 32'sh0100_0000, 0, 0, 0, 0);
    send_item(MODE_SPARE_A, 32'sh7FFF_FFFF, -1, 31'h7FFF_FFFF, 10'h3FF, 10'h3FF, 1'b1);
    send_item(MODE_SPARE_B, 0, 0, 0, 0, 0, 0);
    send_item(MODE_SPARE_C, 0, 0, 0, 0, 0, 0);
    send_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(MODE_PICK_LINE, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);
    drain();
  endtask

  // Mostly well-formed scenes with random content, some noise
  task automatic test_random(input int n_items);
    int sel;
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(99);
      if (vtx_count > 40 || line_count > 12 || sel < 3)
        send_item(MODE_CLEAR, $urandom, $urandom, 31'($urandom), 10'($urandom),
                  10'($urandom), 1'($urandom));
      else if (sel < 35)
        send_item(MODE_ADD_VERTEX, rand_coord(), rand_coord(), 31'($urandom),
                  10'($urandom), 10'($urandom), 1'($urandom));
      else if (sel < 55)
        send_item(MODE_ADD_LINE, $urandom, $urandom, 31'($urandom),
                  ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(vtx_count + 1)),
                  ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(vtx_count + 1)),
                  ($urandom_range(7) != 0));
      else if (sel < 75)
        send_item(MODE_PICK_VERTEX, rand_coord(), rand_coord(), rand_radius(),
                  10'($urandom), 10'($urandom), 1'($urandom));
      else if (sel < 96)
        send_item(MODE_PICK_LINE, rand_coord(), rand_coord(), rand_radius(),
                  10'($urandom), 10'($urandom), 1'($urandom));
      else
        send_item(3'($urandom_range(7, 5)), $urandom, $urandom, 31'($urandom),
                  10'($urandom), 10'($urandom), 1'($urandom));
    end
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    for (int k = 0; k < 8; k++)
      send_item(MODE_ADD_VERTEX, rand_coord(), rand_coord(), 0, 0, 0, 0);
    send_item(MODE_PICK_VERTEX, rand_coord(), rand_coord(), 31'h7FFF_FFFF, 0, 0, 0);
    drain();
  endtask

  initial begin
    vtx_count = 0;  line_count = 0;
    fail_count = 0; sent_count = 0; seen_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(140);
    send_idle_pct = 57; recv_stall_pct = 0;  test_random(130);
    send_idle_pct = 0;  recv_stall_pct = 57; test_random(130);
    send_idle_pct = 7;  recv_stall_pct = 7;  test_random(140);
    test_backpressure();

    repeat (50) @(posedge clk);
    $display("Covered: %0d transfers in, %0d results out, over adds, clears, picks,",
             sent_count, seen_count);
    $display("spare modes, idle and stall phases and a long output hold-off.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
